// ----- hdl/tlvipc_pkg.sv -----
package tlvipc_pkg;

   // parse phases
   localparam logic [3:0] PH_MAGIC   = 4'd0;
   localparam logic [3:0] PH_VERSION = 4'd1;
   localparam logic [3:0] PH_COUNT   = 4'd2;
   localparam logic [3:0] PH_TYPE    = 4'd3;
   localparam logic [3:0] PH_LENGTH  = 4'd4;
   localparam logic [3:0] PH_PAYLOAD = 4'd5;
   localparam logic [3:0] PH_END     = 4'd6;

   // field kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ID   = 2'd1;
   localparam logic [1:0] KIND_CERT = 2'd2;
   localparam logic [1:0] KIND_KEY  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_MAX_PACKAGE = 2'd0;
   localparam logic [1:0] REG_MAX_ID      = 2'd1;
   localparam logic [1:0] REG_MAX_CERT    = 2'd2;
   localparam logic [1:0] REG_MAX_KEY     = 2'd3;

   localparam int CSR_DATA_BITS = 21;

   localparam logic [20:0] RST_MAX_PACKAGE = 21'd262144;
   localparam logic [4:0]  RST_MAX_ID      = 5'd16;
   localparam logic [16:0] RST_MAX_CERT    = 17'd65536;
   localparam logic [17:0] RST_MAX_KEY     = 18'd131072;

   localparam logic [31:0] VERSION_EXPECTED = 32'd1;
   localparam logic [31:0] COUNT_EXPECTED   = 32'd3;

   localparam logic [7:0] MAGIC_BYTES [8] = '{
      8'h4D, 8'h4C, 8'h51, 8'h54, 8'h49, 8'h44, 8'h50, 8'h4B
   };

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       payload_valid;
      logic [1:0] field_kind;
      logic [7:0] payload_byte;
      logic       field_end;
      logic       done_res;
      logic       status;
   } rsp_item_type;

endpackage

// ----- hdl/tlvipc_parser.sv -----
module tlvipc_parser #(
   parameter int COUNT_BITS = 21
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [tlvipc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output tlvipc_pkg::rsp_item_type    item
);
   import tlvipc_pkg::*;

   localparam int CW = (COUNT_BITS > 21) ? COUNT_BITS : 21;

   logic [20:0] max_package_ff;
   logic [4:0]  max_id_ff;
   logic [16:0] max_cert_ff;
   logic [17:0] max_key_ff;

   logic [3:0]            phase_ff, phase_in;
   logic [2:0]            sub_ff, sub_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [31:0]           shift_ff, shift_in;
   logic [17:0]           left_ff, left_in;
   logic [1:0]            field_ff, field_in;
   logic                  failed_ff, failed_in;

   logic [31:0] shift_add;
   logic [2:0]  top;
   logic [17:0] limit;
   logic        hex_ok;
   logic [17:0] left_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_package_ff <= RST_MAX_PACKAGE;
         max_id_ff      <= RST_MAX_ID;
         max_cert_ff    <= RST_MAX_CERT;
         max_key_ff     <= RST_MAX_KEY;
      end else if (csr_write) begin
         case (csr_index)
            REG_MAX_PACKAGE: max_package_ff <= csr_wdata[20:0];
            REG_MAX_ID:      max_id_ff      <= csr_wdata[4:0];
            REG_MAX_CERT:    max_cert_ff    <= csr_wdata[16:0];
            REG_MAX_KEY:     max_key_ff     <= csr_wdata[17:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      shift_add = shift_ff | ({24'b0, data_byte} << {sub_ff[1:0], 3'b000});
      top       = (phase_ff == PH_VERSION || phase_ff == PH_LENGTH) ? 3'd3 : 3'd1;
      hex_ok    = (data_byte inside {[8'h30:8'h39], [8'h61:8'h66]});
      left_dec  = left_ff - 18'd1;
      case (field_ff)
         KIND_ID:   limit = {13'b0, max_id_ff};
         KIND_CERT: limit = {1'b0, max_cert_ff};
         KIND_KEY:  limit = max_key_ff;
         default:   limit = '0;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      sub_in    = sub_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      field_in  = field_ff;
      item      = '0;
      // saturating byte count
      total_in  = (&total_ff) ? total_ff : total_ff + 1'b1;
      failed_in = failed_ff || (CW'(total_in) > CW'(max_package_ff));

      if (!failed_in) begin
         case (phase_ff)
            PH_MAGIC: begin
               if (data_byte != MAGIC_BYTES[sub_ff]) begin
                  failed_in = 1'b1;
               end else if (sub_ff == 3'd7) begin
                  phase_in = PH_VERSION;
                  sub_in   = '0;
                  shift_in = '0;
               end else begin
                  sub_in = sub_ff + 3'd1;
               end
            end
            PH_VERSION, PH_COUNT, PH_TYPE, PH_LENGTH: begin
               if (sub_ff < top) begin
                  sub_in   = sub_ff + 3'd1;
                  shift_in = shift_add;
               end else begin
                  sub_in   = '0;
                  shift_in = '0;
                  case (phase_ff)
                     PH_VERSION: begin
                        if (shift_add != VERSION_EXPECTED) failed_in = 1'b1;
                        else phase_in = PH_COUNT;
                     end
                     PH_COUNT: begin
                        if (shift_add != COUNT_EXPECTED) begin
                           failed_in = 1'b1;
                        end else begin
                           phase_in = PH_TYPE;
                           field_in = KIND_ID;
                        end
                     end
                     PH_TYPE: begin
                        if (shift_add != {30'b0, field_ff}) failed_in = 1'b1;
                        else phase_in = PH_LENGTH;
                     end
                     default: begin
                        // length: nonzero, not negative, within the field limit
                        if (shift_add == '0 || shift_add[31] ||
                            shift_add > {14'b0, limit}) begin
                           failed_in = 1'b1;
                        end else begin
                           left_in  = shift_add[17:0];
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  endcase
               end
            end
            PH_PAYLOAD: begin
               if (left_ff == '0 || (field_ff == KIND_ID && !hex_ok)) begin
                  failed_in = 1'b1;
               end else begin
                  item.payload_valid = 1'b1;
                  item.field_kind    = field_ff;
                  item.payload_byte  = data_byte;
                  left_in            = left_dec;
                  if (left_dec == '0) begin
                     item.field_end = 1'b1;
                     if (field_ff == KIND_KEY) begin
                        phase_in = PH_END;
                     end else begin
                        field_in = field_ff + 2'd1;
                        phase_in = PH_TYPE;
                     end
                  end
               end
            end
            default: failed_in = 1'b1;
         endcase
      end

      if (last_byte) begin
         item.done_res = 1'b1;
         item.status   = failed_in || (phase_in != PH_END);
         // drop all parse state for the next package
         phase_in  = PH_MAGIC;
         sub_in    = '0;
         total_in  = '0;
         shift_in  = '0;
         left_in   = '0;
         field_in  = KIND_NONE;
         failed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         sub_ff    <= '0;
         total_ff  <= '0;
         shift_ff  <= '0;
         left_ff   <= '0;
         field_ff  <= KIND_NONE;
         failed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         sub_ff    <= sub_in;
         total_ff  <= total_in;
         shift_ff  <= shift_in;
         left_ff   <= left_in;
         field_ff  <= field_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// ----- hdl/tlvipc_queue.sv -----
module tlvipc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tlvipc_pkg::rsp_item_type push_item,
   input  logic                     pop,
   output tlvipc_pkg::rsp_item_type head,
   output logic                     nonempty,
   output logic                     full
);
   import tlvipc_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   rsp_item_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign head     = slot_ff[rd_ff];
   assign nonempty = (count_ff != '0);
   assign full     = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/tlvipc_emit.sv -----
module tlvipc_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  tlvipc_pkg::rsp_item_type head,
   input  logic                     nonempty,
   output logic                     pop,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output tlvipc_pkg::rsp_item_type rsp_item
);
   import tlvipc_pkg::*;

   logic         valid_ff;
   rsp_item_type item_ff;
   logic         load;

   // refill the output register when it is empty or its transfer completes
   assign load      = !valid_ff || !rsp_stall;
   assign pop       = load && nonempty;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= nonempty;
   end

   always_ff @(posedge clock) begin
      if (pop) item_ff <= head;
   end

endmodule

// ----- hdl/tlv_identity_package_checker_unit.sv -----
// Identity package checker: streams a package one byte per transfer and checks
// its magic, version, field count and the three type-length-value fields.
//
// Input channel (req_): one package byte per transfer, req_last_byte on the
// final byte. A transfer completes when req_valid is high and req_stall low.
// Result channel (rsp_): exactly one result per input byte, in order. Payload
// bytes come out tagged with their field kind; the result for the final byte
// carries rsp_done_res and rsp_status (0 accepted, 1 invalid).
// Config channel (csr_): register index and data, written when csr_valid and
// csr_ready are both high; write only while no package is in flight.
//
// Input bytes are taken one per cycle while req_stall is low; the parser state
// updates on each accepted byte. A result passes from the input transfer into
// a four-entry result queue, then the output register that drives rsp_valid.
// When the receiver holds rsp_stall, results collect in the queue; req_stall
// rises once the queue is full and falls as soon as an entry drains.
// Synchronous reset clears the parser, queue and output register and restores
// the register defaults; both channels stall while reset is high.
module tlv_identity_package_checker_unit #(
   parameter int COUNT_BITS = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_payload_valid,
   output logic [1:0]  rsp_field_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_field_end,
   output logic        rsp_done_res,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [tlvipc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import tlvipc_pkg::*;

   logic         req_accept;
   logic         csr_write;
   rsp_item_type parsed_item;
   rsp_item_type queue_head;
   rsp_item_type out_item;
   logic         queue_nonempty;
   logic         queue_full;
   logic         queue_pop;

   // hold the input off while the queue is full or reset is active
   assign req_stall  = queue_full || reset;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !reset;
   assign csr_write  = csr_valid && csr_ready;

   // front: classify each byte and advance the parse state
   tlvipc_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (parsed_item)
   );

   // queue between front and back
   tlvipc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (parsed_item),
      .pop       (queue_pop),
      .head      (queue_head),
      .nonempty  (queue_nonempty),
      .full      (queue_full)
   );

   // back: output register toward the receiver
   tlvipc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .nonempty  (queue_nonempty),
      .pop       (queue_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (out_item)
   );

   assign rsp_payload_valid = out_item.payload_valid;
   assign rsp_field_kind    = out_item.field_kind;
   assign rsp_payload_byte  = out_item.payload_byte;
   assign rsp_field_end     = out_item.field_end;
   assign rsp_done_res      = out_item.done_res;
   assign rsp_status        = out_item.status;

endmodule

// ----- hdl/tlvipc_checker.sv -----
module tlvipc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_payload_valid,
   input logic [1:0] rsp_field_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_field_end,
   input logic       rsp_done_res,
   input logic       rsp_status
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_valid) &&
         $stable(rsp_field_kind) && $stable(rsp_payload_byte) &&
         $stable(rsp_field_end) && $stable(rsp_done_res) && $stable(rsp_status))
      else $error("stalled result changed");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a result appearing on an idle output comes from an input transfer through the queue and output register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without input transfer");

   // an invalid status only comes with the final-byte result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_done_res && !(rsp_field_end && !rsp_payload_valid))
      else $error("status outside final result");

endmodule

bind tlv_identity_package_checker_unit tlvipc_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_field_kind    (rsp_field_kind),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_field_end     (rsp_field_end),
   .rsp_done_res      (rsp_done_res),
   .rsp_status        (rsp_status)
);
